FILE: rtl/core/mvm_pkg.sv
// shared constants, codes and control types of the matrix-vector multiply block
// no dependencies
package mvm_pkg;

   localparam int MAX_DIM     = 16;
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = IDX_W + 1;
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int MAT_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int SUM_W       = 32;
   localparam int PROD_W      = 2 * VALUE_WIDTH;
   localparam int ACC_W       = PROD_W + IDX_W;
   localparam int RND_W       = ACC_W - FRAC_BITS;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic [DIM_W-1:0] DIM_ONE    = DIM_W'(1);
   localparam logic [DIM_W-1:0] DIM_MAX    = DIM_W'(MAX_DIM);

   localparam logic [1:0] OP_WRITE_MATRIX = 2'd0;
   localparam logic [1:0] OP_WRITE_VECTOR = 2'd1;
   localparam logic [1:0] OP_COMPUTE      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORDER_MODE    = 2'd3;

   typedef struct packed {
      logic                   mat_we;
      logic                   vec_we;
      logic [ADDR_W-1:0]      mat_waddr;
      logic [IDX_W-1:0]       vec_waddr;
      logic [VALUE_WIDTH-1:0] wdata;
      logic                   rd_en;
      logic [ADDR_W-1:0]      mat_raddr;
      logic [IDX_W-1:0]       vec_raddr;
      logic                   acc_clear;
   } mvm_ctrl_type;

   typedef struct packed {
      logic             busy;
      logic [SUM_W-1:0] sum;
   } mvm_stat_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [CSR_DATA_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) r = DIM_ONE;
      else if (DIM_W'(d) > DIM_MAX) r = DIM_MAX;
      else r = DIM_W'(d);
      return r;
   endfunction

endpackage

FILE: rtl/core/mvm_ifaces.sv
// request and response channel interfaces of the matrix-vector multiply block
// depends on mvm_pkg
interface mvm_req_if import mvm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [3:0]          row_index;
   logic [3:0]          col_index;
   logic signed [31:0]  value;

   modport source (output valid, op, row_index, col_index, value, input ready);
   modport sink (input valid, op, row_index, col_index, value, output ready);
endinterface

interface mvm_rsp_if import mvm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [3:0]          position;
   logic signed [31:0]  sum;
   logic                last;
   logic                mismatch;

   modport source (output valid, position, sum, last, mismatch, input ready);
   modport sink (input valid, position, sum, last, mismatch, output ready);
endinterface

FILE: rtl/core/mvm_datapath.sv
// matrix and vector stores, shared multiply-accumulate unit, rounding and saturation
// depends on mvm_pkg
module mvm_datapath import mvm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mvm_ctrl_type ctrl,
   output mvm_stat_type stat
);

   logic [VALUE_WIDTH-1:0] mat_mem [MAT_DEPTH];
   logic [VALUE_WIDTH-1:0] vec_mem [MAX_DIM];

   logic signed [VALUE_WIDTH-1:0] mat_rd_ff;
   logic signed [VALUE_WIDTH-1:0] vec_rd_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic                          rd_valid_ff;
   logic                          mul_valid_ff;

   logic [ACC_W-1:0]       acc_rnd;
   logic [RND_W-1:0]       rnd;
   logic [RND_W-VALUE_WIDTH:0] rnd_hi;
   logic                   fits;
   logic [VALUE_WIDTH-1:0] sat;

   always_ff @(posedge clock) begin
      if (ctrl.mat_we) begin
         mat_mem[ctrl.mat_waddr] <= ctrl.wdata;
      end
      if (ctrl.vec_we) begin
         vec_mem[ctrl.vec_waddr] <= ctrl.wdata;
      end
      if (ctrl.rd_en) begin
         mat_rd_ff <= mat_mem[ctrl.mat_raddr];
         vec_rd_ff <= vec_mem[ctrl.vec_raddr];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mat_rd_ff * vec_rd_ff;
      if (ctrl.acc_clear) begin
         acc_ff <= '0;
      end else if (mul_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= ctrl.rd_en;
         mul_valid_ff <= rd_valid_ff;
      end
   end

   // round to nearest, ties up, then saturate
   always_comb begin
      acc_rnd = acc_ff + ROUND_HALF;
      rnd     = acc_rnd[ACC_W-1:FRAC_BITS];
      rnd_hi  = rnd[RND_W-1:VALUE_WIDTH-1];
      fits    = (&rnd_hi) || (~|rnd_hi);
      if (fits) begin
         sat = rnd[VALUE_WIDTH-1:0];
      end else if (rnd[RND_W-1]) begin
         sat = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         sat = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
      stat.sum  = SUM_W'($signed(sat));
      stat.busy = rd_valid_ff | mul_valid_ff;
   end

endmodule

FILE: rtl/core/matrix_vector_multiply_top.sv
// Matrix-vector multiply, Q16.16. For a compute request, one shared 32x32
// multiply-accumulate unit walks every matrix entry in use, one entry a cycle within a row,
// followed by pipeline drain and rounding per result. A length mismatch is answered in the
// cycle after the request is accepted.
// depends on mvm_pkg, mvm_ifaces, mvm_datapath
module matrix_vector_multiply_top import mvm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mvm_req_if.sink               req_chan,
   mvm_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_ROUND
   } state_type;

   state_type state_ff;

   logic [CSR_DATA_W-1:0] num_rows_ff;
   logic [CSR_DATA_W-1:0] num_cols_ff;
   logic [CSR_DATA_W-1:0] vector_length_ff;
   logic                  order_mode_ff;

   logic [IDX_W-1:0]  row_ff;
   logic [IDX_W-1:0]  col_ff;
   logic [ADDR_W-1:0] addr_ff;

   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_position_ff;
   logic [SUM_W-1:0]  rsp_sum_ff;
   logic              rsp_last_ff;
   logic              rsp_mismatch_ff;

   logic [DIM_W-1:0] rows_dim;
   logic [DIM_W-1:0] cols_dim;
   logic [DIM_W-1:0] vlen_dim;
   logic [DIM_W-1:0] outer_dim;
   logic [DIM_W-1:0] inner_dim;
   logic             mismatch;
   logic             req_accept;
   logic             slot_free;
   logic             row_last;
   logic             col_last;
   logic             rsp_load;

   mvm_ctrl_type ctrl;
   mvm_stat_type dp_stat;

   mvm_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (dp_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff      <= CSR_DATA_W'(MAX_DIM);
         num_cols_ff      <= CSR_DATA_W'(MAX_DIM);
         vector_length_ff <= CSR_DATA_W'(MAX_DIM);
         order_mode_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_NUM_ROWS:      num_rows_ff      <= csr_write_data;
            REG_NUM_COLS:      num_cols_ff      <= csr_write_data;
            REG_VECTOR_LENGTH: vector_length_ff <= csr_write_data;
            REG_ORDER_MODE:    order_mode_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rows_dim   = eff_dim(num_rows_ff);
      cols_dim   = eff_dim(num_cols_ff);
      vlen_dim   = eff_dim(vector_length_ff);
      outer_dim  = order_mode_ff ? cols_dim : rows_dim;
      inner_dim  = order_mode_ff ? rows_dim : cols_dim;
      mismatch   = order_mode_ff ? (rows_dim != vlen_dim) : (cols_dim != vlen_dim);
      slot_free  = !rsp_valid_ff || rsp_chan.ready;
      row_last   = {1'b0, row_ff} == (outer_dim - DIM_ONE);
      col_last   = {1'b0, col_ff} == (inner_dim - DIM_ONE);
      req_chan.ready = (state_ff == ST_IDLE) && slot_free;
      req_accept = req_chan.valid && req_chan.ready;
      rsp_load   = (req_accept && (req_chan.op == OP_COMPUTE) && mismatch)
                   || ((state_ff == ST_ROUND) && slot_free);

      ctrl           = '0;
      ctrl.wdata     = req_chan.value[VALUE_WIDTH-1:0];
      ctrl.mat_waddr = ADDR_W'(ADDR_W'(req_chan.row_index) * ADDR_W'(cols_dim)
                               + ADDR_W'(req_chan.col_index));
      ctrl.vec_waddr = req_chan.col_index;
      ctrl.mat_we    = req_accept && (req_chan.op == OP_WRITE_MATRIX)
                       && ({1'b0, req_chan.row_index} < rows_dim)
                       && ({1'b0, req_chan.col_index} < cols_dim);
      ctrl.vec_we    = req_accept && (req_chan.op == OP_WRITE_VECTOR);
      ctrl.rd_en     = state_ff == ST_ISSUE;
      ctrl.mat_raddr = addr_ff;
      ctrl.vec_raddr = col_ff;
      ctrl.acc_clear = (req_accept && (req_chan.op == OP_COMPUTE) && !mismatch)
                       || ((state_ff == ST_ROUND) && slot_free && !row_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_chan.op == OP_COMPUTE)) begin
                  if (mismatch) begin
                     rsp_position_ff <= '0;
                     rsp_sum_ff      <= '0;
                     rsp_last_ff     <= 1'b1;
                     rsp_mismatch_ff <= 1'b1;
                  end else begin
                     row_ff   <= '0;
                     col_ff   <= '0;
                     addr_ff  <= '0;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            ST_ISSUE: begin
               if (col_last) begin
                  col_ff   <= '0;
                  addr_ff  <= order_mode_ff ? ADDR_W'(row_ff) + ADDR_W'(1)
                                            : addr_ff + ADDR_W'(1);
                  state_ff <= ST_DRAIN;
               end else begin
                  col_ff  <= col_ff + IDX_W'(1);
                  addr_ff <= order_mode_ff ? addr_ff + ADDR_W'(cols_dim)
                                           : addr_ff + ADDR_W'(1);
               end
            end
            ST_DRAIN: begin
               if (!dp_stat.busy) begin
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               if (slot_free) begin
                  rsp_position_ff <= row_ff;
                  rsp_sum_ff      <= dp_stat.sum;
                  rsp_last_ff     <= row_last;
                  rsp_mismatch_ff <= 1'b0;
                  if (row_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     row_ff   <= row_ff + IDX_W'(1);
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.position = rsp_position_ff;
   assign rsp_chan.sum      = rsp_sum_ff;
   assign rsp_chan.last     = rsp_last_ff;
   assign rsp_chan.mismatch = rsp_mismatch_ff;

`ifndef ASSERT_OFF
   a_mismatch_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mismatch_ff) |-> (rsp_last_ff && (rsp_sum_ff == '0)))
      else $error("mismatch response not final or nonzero");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !dp_stat.busy)
      else $error("mac pipeline busy while idle");

   a_clear_when_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.acc_clear |-> !dp_stat.busy)
      else $error("accumulator cleared with products in flight");

   a_position_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_mismatch_ff) |-> ({1'b0, rsp_position_ff} < outer_dim))
      else $error("response position beyond result length");
`endif

endmodule
